// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/cbc_pkg.sv
// shared types and constants for the cartridge bank controller
package cbc_pkg;

	localparam int RAM_BYTES     = 32768;
	localparam int RAM_AW        = $clog2(RAM_BYTES);
	localparam int RAM_BANK_BITS = 2;
	localparam int RAM_OFS_BITS  = 13;
	localparam int ROM_BANK_BITS = 7;
	localparam int ROM_OFS_BITS  = 14;

	localparam logic [ROM_BANK_BITS-1:0] ROM_BANK_RESET = ROM_BANK_BITS'(1);
	localparam logic [3:0]               RAM_EN_KEY     = 4'hA;
	localparam logic [7:0]               RAM_BANK_MAX   = 8'h03;
	localparam logic [7:0]               UNMAPPED_DATA  = 8'hFF;

	typedef enum logic [1:0] {
		REQ_ROM_READ  = 2'd0,
		REQ_REG_WRITE = 2'd1,
		REQ_RAM_READ  = 2'd2,
		REQ_RAM_WRITE = 2'd3
	} req_t;

	// register windows selected by address[15:13]
	localparam logic [2:0] REG_RAM_EN   = 3'd0;
	localparam logic [2:0] REG_ROM_BANK = 3'd1;
	localparam logic [2:0] REG_RAM_BANK = 3'd2;
	localparam logic [2:0] REG_MODE     = 3'd3;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [20:0] rom_address;
		logic        rom_fetch;
		logic        ram_enabled;
	} res_t;

endpackage

// File: rtl/core/cbc_ram.sv
// banked cartridge ram, one port, registered read data
module cbc_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic                      re,
	input  logic [cbc_pkg::RAM_AW-1:0] addr,
	input  logic [7:0]                wdata,
	output logic [7:0]                rdata
);
	import cbc_pkg::*;

	logic [7:0] mem_q [RAM_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/cbc_out_skid.sv
// output register with skid slot so input ready comes from a flop
module cbc_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	input  cbc_pkg::res_t s_res,
	output logic          out_valid,
	input  logic          out_ready,
	output cbc_pkg::res_t out_res
);
	import cbc_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_res_q;
	res_t skid_res_q;
	logic out_free;
	logic s_move;

	assign out_free = !out_valid_q || out_ready;
	assign s_move   = s_valid && !skid_valid_q;
	assign s_ready  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (skid_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (s_move && out_free) begin
				out_valid_q <= 1'b1;
			end else if (s_move) begin
				skid_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_valid_q && out_free) begin
			out_res_q <= skid_res_q;
		end else if (s_move && out_free) begin
			out_res_q <= s_res;
		end else if (s_move) begin
			skid_res_q <= s_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`include "assert_macros.svh"

	`ASSERT_IMPL(skid_only_behind_out, skid_valid_q, out_valid_q)
	`ASSERT_NEXT(skid_holds_on_stall, skid_valid_q && !out_ready, skid_valid_q)
	`ASSERT_NEXT(skid_fills_on_stall, s_valid && !skid_valid_q && out_valid_q && !out_ready,
		skid_valid_q)

endmodule

// File: rtl/core/cartridge_bank_controller_core.sv
// Banked cartridge controller: takes one bus transaction per clock while in_ready is high and
// returns one result transaction for each, in order. Each result is registered first in the
// request stage, whose ram data comes from the single-port internal ram (registered read), and
// then in the output register with its skid slot, which keeps in_ready a flop output. Bank, enable
// and mode registers update at acceptance, so each access sees all earlier writes. ROM reads
// below 0x8000 return the physical address for the external ROM with rom_fetch set; the ram is
// not gated by the enable bit and its contents are undefined until written.
module cartridge_bank_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [20:0] rom_address,
	output logic        rom_fetch,
	output logic        ram_enabled
);
	import cbc_pkg::*;

	req_t req;
	logic accept;

	logic [ROM_BANK_BITS-1:0] rom_sel_q, rom_sel_d, bank_wr;
	logic [RAM_BANK_BITS-1:0] ram_sel_q, ram_sel_d;
	logic                     ram_en_q, ram_en_d;
	logic [7:0]               mode_q, mode_d;

	logic [RAM_BANK_BITS+RAM_OFS_BITS-1:0] ram_idx_full;
	logic [RAM_AW-1:0]                     ram_addr;
	logic [7:0]                            ram_rdata;
	logic                                  ram_we, ram_re;

	logic        fetch_d, unmapped_d;
	logic [20:0] rom_addr_d;

	logic        valid_s1;
	logic        rd_ram_s1, unmapped_s1, fetch_s1, ram_en_s1;
	logic [20:0] rom_addr_s1;
	res_t        res_s1;
	res_t        out_res;
	logic        s1_ready;

	assign req    = req_t'(req_type);
	assign accept = in_valid && in_ready;

	// register writes in the rom window
	assign bank_wr = write_data[ROM_BANK_BITS-1:0];

	always_comb begin
		rom_sel_d = rom_sel_q;
		ram_sel_d = ram_sel_q;
		ram_en_d  = ram_en_q;
		mode_d    = mode_q;
		if (accept && req == REQ_REG_WRITE) begin
			unique case (address[15:13])
				REG_RAM_EN: begin
					ram_en_d = (write_data[3:0] == RAM_EN_KEY);
				end
				REG_ROM_BANK: begin
					rom_sel_d = (bank_wr == '0) ? ROM_BANK_RESET : bank_wr;
				end
				REG_RAM_BANK: begin
					if (write_data <= RAM_BANK_MAX) begin
						ram_sel_d = write_data[RAM_BANK_BITS-1:0];
					end
				end
				REG_MODE: begin
					mode_d = write_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_sel_q <= ROM_BANK_RESET;
			ram_sel_q <= '0;
			ram_en_q  <= 1'b0;
			mode_q    <= '0;
		end else begin
			rom_sel_q <= rom_sel_d;
			ram_sel_q <= ram_sel_d;
			ram_en_q  <= ram_en_d;
			mode_q    <= mode_d;
		end
	end

	// ram index wraps to the ram size
	assign ram_idx_full = {ram_sel_q, address[RAM_OFS_BITS-1:0]};
	assign ram_addr     = ram_idx_full[RAM_AW-1:0];
	assign ram_we       = accept && req == REQ_RAM_WRITE;
	assign ram_re       = accept && req == REQ_RAM_READ;

	cbc_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (write_data),
		.rdata (ram_rdata)
	);

	// rom mapping: fixed bank below 0x4000, switchable bank up to 0x7fff
	always_comb begin
		fetch_d    = (req == REQ_ROM_READ) && !address[15];
		unmapped_d = (req == REQ_ROM_READ) && address[15];
		rom_addr_d = '0;
		if (fetch_d) begin
			if (address[14]) begin
				rom_addr_d = 21'({rom_sel_q, address[ROM_OFS_BITS-1:0]});
			end else begin
				rom_addr_d = 21'(address[ROM_OFS_BITS-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ram_s1   <= (req == REQ_RAM_READ);
			unmapped_s1 <= unmapped_d;
			fetch_s1    <= fetch_d;
			rom_addr_s1 <= rom_addr_d;
			ram_en_s1   <= ram_en_d;
		end
	end

	always_comb begin
		res_s1.read_data   = rd_ram_s1 ? ram_rdata : (unmapped_s1 ? UNMAPPED_DATA : 8'h00);
		res_s1.rom_address = rom_addr_s1;
		res_s1.rom_fetch   = fetch_s1;
		res_s1.ram_enabled = ram_en_s1;
	end

	cbc_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (valid_s1),
		.s_ready   (s1_ready),
		.s_res     (res_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign in_ready    = s1_ready;
	assign read_data   = out_res.read_data;
	assign rom_address = out_res.rom_address;
	assign rom_fetch   = out_res.rom_fetch;
	assign ram_enabled = out_res.ram_enabled;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(rom_sel_nonzero, rom_sel_q != '0)
	`ASSERT_NEXT(ram_read_tracked, accept && req == REQ_RAM_READ, valid_s1 && rd_ram_s1)
	`ASSERT_IMPL(stage_holds_when_blocked, valid_s1 && !s1_ready, !accept)

endmodule

// File: bench/tb_cartridge_bank_controller_core.sv
`timescale 1ns / 1ps
// testbench for the cartridge bank controller core: bus transactions checked against a bank predictor

import cbc_pkg::*;

class bank_scoreboard;
	logic [ROM_BANK_BITS-1:0] rom_sel;
	logic [RAM_BANK_BITS-1:0] ram_sel;
	logic ram_en;
	logic [7:0] mode_reg;
	logic [7:0] ram_mem [RAM_BYTES];
	bit ram_written [RAM_BYTES];
	// offsets already written, per ram bank, so reads never hit undefined bytes
	logic [RAM_OFS_BITS-1:0] written_ofs [1 << RAM_BANK_BITS][$];
	res_t expected_q [$];
	int unsigned errors;

	function new();
		rom_sel = ROM_BANK_RESET;
		ram_sel = '0;
		ram_en = 1'b0;
		mode_reg = '0;
		errors = 0;
	endfunction

	function int unsigned outstanding();
		return expected_q.size();
	endfunction

	function void note_access(req_t req, logic [15:0] addr, logic [7:0] data);
		res_t r;
		logic [RAM_AW-1:0] idx;
		r = '0;
		idx = {ram_sel, addr[RAM_OFS_BITS-1:0]};
		case (req)
		REQ_ROM_READ: begin
			if (!addr[15]) begin
				r.rom_fetch = 1'b1;
				r.rom_address = addr[14] ? {rom_sel, addr[ROM_OFS_BITS-1:0]} : 21'(addr);
			end else begin
				r.read_data = UNMAPPED_DATA;
			end
		end
		REQ_REG_WRITE: begin
			case (addr[15:13])
			REG_RAM_EN: ram_en = (data[3:0] == RAM_EN_KEY);
			REG_ROM_BANK: begin
				rom_sel = data[ROM_BANK_BITS-1:0];
				// bank zero after masking selects bank one
				if (rom_sel == '0)
					rom_sel = ROM_BANK_BITS'(1);
			end
			REG_RAM_BANK: begin
				if (data <= RAM_BANK_MAX)
					ram_sel = data[RAM_BANK_BITS-1:0];
			end
			REG_MODE: mode_reg = data;
			default: ;
			endcase
		end
		REQ_RAM_READ: r.read_data = ram_mem[idx];
		default: begin
			ram_mem[idx] = data;
			if (!ram_written[idx]) begin
				ram_written[idx] = 1'b1;
				written_ofs[ram_sel].push_back(addr[RAM_OFS_BITS-1:0]);
			end
		end
		endcase
		r.ram_enabled = ram_en;
		expected_q.push_back(r);
	endfunction

	function void compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result, expected none actual %h", $time, got);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		compare_field("read_data", want.read_data, got.read_data);
		compare_field("rom_address", want.rom_address, got.rom_address);
		compare_field("rom_fetch", want.rom_fetch, got.rom_fetch);
		compare_field("ram_enabled", want.ram_enabled, got.ram_enabled);
	endfunction
endclass

module tb_cartridge_bank_controller_core;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = REQ_ROM_READ;
	logic [15:0] address = '0;
	logic [7:0] write_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_data;
	logic [20:0] rom_address;
	logic rom_fetch;
	logic ram_enabled;

	bit out_quiet = 1'b0;
	bank_scoreboard sb = new();

	cartridge_bank_controller_core dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= out_quiet || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(res_t'({read_data, rom_address, rom_fetch, ram_enabled}));
	end

	// one transaction; returns at the edge where it was taken, valid still high
	task send_access(req_t req, logic [15:0] addr, logic [7:0] data);
		in_valid <= 1'b1;
		req_type <= req;
		address <= addr;
		write_data <= data;
		do @(posedge clk); while (!in_ready);
		sb.note_access(req, addr, data);
	endtask

	task idle_cycles();
		int n;
		n = 1;
		while ($urandom_range(99) < 27)
			n++;
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task drain_outstanding();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task random_access(output bit counted);
		int k;
		int w;
		int n;
		req_t req;
		logic [2:0] win;
		logic [15:0] addr;
		logic [7:0] data;
		k = $urandom_range(99);
		addr = 16'($urandom);
		data = 8'($urandom);
		counted = 1'b1;
		n = sb.written_ofs[sb.ram_sel].size();
		if (k < 25) begin
			req = REQ_ROM_READ;
		end else if (k < 50) begin
			req = REQ_REG_WRITE;
			w = $urandom_range(7);
			case (w)
			0, 1: begin
				win = REG_RAM_EN;
				if ($urandom_range(1))
					data = {4'($urandom), RAM_EN_KEY};
			end
			2, 3: begin
				win = REG_ROM_BANK;
				if ($urandom_range(7) == 0)
					data = {1'($urandom), 7'd0};
			end
			4, 5: begin
				win = REG_RAM_BANK;
				if ($urandom_range(3) != 0)
					data = 8'($urandom_range(0, RAM_BANK_MAX));
			end
			6: win = REG_MODE;
			default: win = 3'($urandom_range(4, 7));
			endcase
			addr = {win, 13'($urandom)};
			// writes the block throws away
			if (win[2] || (win == REG_RAM_BANK && data > RAM_BANK_MAX))
				counted = 1'b0;
		end else if (k < 75 || n == 0) begin
			req = REQ_RAM_WRITE;
			// a narrow window most of the time so bytes get rewritten and read back
			if ($urandom_range(99) < 60)
				addr[RAM_OFS_BITS-1:0] = 13'($urandom_range(63));
		end else begin
			req = REQ_RAM_READ;
			addr = {3'($urandom), sb.written_ofs[sb.ram_sel][$urandom_range(n - 1)]};
		end
		send_access(req, addr, data);
	endtask

	initial begin
		bit counted;
		int issued;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_access(REQ_ROM_READ, 16'h0000, 8'h00);
		send_access(REQ_ROM_READ, 16'h3FFF, 8'hFF);
		send_access(REQ_ROM_READ, 16'h4000, 8'h00);
		send_access(REQ_ROM_READ, 16'hFFFF, 8'h00);
		send_access(REQ_ROM_READ, 16'h8000, 8'h00);
		send_access(REQ_REG_WRITE, 16'h2000, 8'h00);
		send_access(REQ_ROM_READ, 16'h4000, 8'h00);
		// high bit only: zero after masking
		send_access(REQ_REG_WRITE, 16'h3FFF, 8'h80);
		send_access(REQ_ROM_READ, 16'h7FFF, 8'h00);
		send_access(REQ_REG_WRITE, 16'h2ABC, 8'hFF);
		send_access(REQ_ROM_READ, 16'h7FFF, 8'h00);
		send_access(REQ_REG_WRITE, 16'h0000, 8'h0A);
		send_access(REQ_REG_WRITE, 16'h1FFF, 8'hA0);
		send_access(REQ_REG_WRITE, 16'h1234, 8'hFA);
		send_access(REQ_REG_WRITE, 16'h8000, 8'h00);
		send_access(REQ_REG_WRITE, 16'hFFFF, 8'h00);
		send_access(REQ_REG_WRITE, 16'h4000, 8'h03);
		send_access(REQ_REG_WRITE, 16'h5FFF, 8'h04);
		send_access(REQ_REG_WRITE, 16'h6000, 8'hFF);
		send_access(REQ_REG_WRITE, 16'h7FFF, 8'h00);
		// ram stays usable with the enable cleared
		send_access(REQ_REG_WRITE, 16'h0000, 8'h00);
		send_access(REQ_RAM_WRITE, 16'hA000, 8'h5A);
		send_access(REQ_RAM_READ, 16'hE000, 8'h00);
		send_access(REQ_RAM_WRITE, 16'hBFFF, 8'hFF);
		send_access(REQ_RAM_READ, 16'h1FFF, 8'h00);

		issued = 0;
		while (issued < 1800) begin
			out_quiet = (issued >= 700 && issued < 1000);
			random_access(counted);
			if (counted)
				issued++;
			if (counted && issued == 1200)
				drain_outstanding();
			else if (!out_quiet && $urandom_range(99) < 27)
				idle_cycles();
		end
		out_quiet = 1'b0;
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
